// ===== hdl/vbde_pkg.sv =====
// Shared types and constants for the variable-byte posting delta encoder.
// No dependencies; imported by the controller, the datapath and the top level.
package vbde_pkg;

  localparam int unsigned DocWidth   = 31;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned PosWidth   = 32;
  localparam int unsigned InDataWidth  = 96;
  localparam int unsigned OutDataWidth = 8;

  localparam logic [6:0] GroupMask = 7'h7f;
  localparam logic [7:0] ContBit   = 8'h80;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DOC,
    ST_CNT,
    ST_POS
  } vbde_state_t;

  // Source for the varint shift register when the current varint ends.
  typedef enum logic [1:0] {
    LD_SHIFT,
    LD_COUNT,
    LD_DELTA
  } vbde_load_t;

  typedef struct packed {
    logic       accept;
    logic       emit;
    logic       last;
    vbde_load_t load;
  } vbde_cmd_t;

  typedef struct packed {
    logic more;      // value left in the shift register needs another byte
    logic cnt_multi; // latched count is above one
    logic out_free;  // output register can take a beat this cycle
  } vbde_status_t;

endpackage

// ===== hdl/vbde_ctrl.sv =====
// Controller state machine for the posting delta encoder.
// Depends on vbde_pkg; drives commands into vbde_dp from its status.
module vbde_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_first,
  input  vbde_pkg::vbde_status_t status,
  output logic                  in_ready,
  output vbde_pkg::vbde_cmd_t   cmd
);
  import vbde_pkg::*;

  vbde_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = in_first ? ST_DOC : ST_POS;
        end
      end
      ST_DOC: begin
        if (status.out_free && !status.more) begin
          state_next = status.cnt_multi ? ST_CNT : ST_POS;
        end
      end
      ST_CNT: begin
        if (status.out_free && !status.more) begin
          state_next = ST_POS;
        end
      end
      ST_POS: begin
        if (status.out_free && !status.more) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.emit   = 1'b0;
    cmd.last   = 1'b0;
    cmd.load   = LD_SHIFT;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DOC: begin
        cmd.emit = status.out_free;
        if (!status.more) begin
          cmd.load = status.cnt_multi ? LD_COUNT : LD_DELTA;
        end
      end
      ST_CNT: begin
        cmd.emit = status.out_free;
        if (!status.more) begin
          cmd.load = LD_DELTA;
        end
      end
      ST_POS: begin
        cmd.emit = status.out_free;
        cmd.last = !status.more;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/vbde_dp.sv =====
// Datapath for the posting delta encoder: input latches, previous position,
// varint shift register and the output register. Depends on vbde_pkg.
module vbde_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_first,
  input  logic [vbde_pkg::DocWidth-1:0]       in_doc,
  input  logic [vbde_pkg::CountWidth-1:0]     in_count,
  input  logic [vbde_pkg::PosWidth-1:0]       in_pos,
  input  vbde_pkg::vbde_cmd_t                 cmd,
  output vbde_pkg::vbde_status_t              status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [vbde_pkg::OutDataWidth-1:0]   out_byte,
  output logic                                out_last
);
  import vbde_pkg::*;

  logic [PosWidth-1:0]   previous_position;
  logic [CountWidth-1:0] count;
  logic [PosWidth-1:0]   delta;
  logic [31:0]           shreg;
  logic [31:0]           head;
  logic [PosWidth-1:0]   delta_next;
  logic                  more;

  assign head       = {in_doc, (in_count == 32'd1)};
  assign delta_next = in_first ? in_pos : (in_pos - previous_position);
  assign more       = (shreg[31:7] != 25'd0);

  assign status.more      = more;
  assign status.cnt_multi = (count > 32'd1);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_position <= '0;
    end else if (cmd.accept) begin
      previous_position <= in_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      count <= in_count;
      delta <= delta_next;
      shreg <= in_first ? head : delta_next;
    end else if (cmd.emit) begin
      case (cmd.load)
        LD_COUNT: shreg <= count;
        LD_DELTA: shreg <= delta;
        default:  shreg <= {7'd0, shreg[31:7]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= (more ? ContBit : 8'h00) | {1'b0, shreg[6:0] & GroupMask};
      out_last <= cmd.last;
    end
  end

endmodule

// ===== hdl/posting_vbyte_delta_encoder.sv =====
// Variable-byte posting encoder with delta-coded positions (top level).
// An accepted beat loads the varint shift register; the item's first byte is then
// registered onto m_tdata. Throughput: one byte per cycle while m_tready does not
// stall; a new beat is taken only once the previous item's last byte is emitted.
// Reset: rst is synchronous and active high; it clears the state machine, the
// output valid and the previous position to zero. Depends on vbde_ctrl, vbde_dp.
module posting_vbyte_delta_encoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // Fields from bit 0: document_number[30:0], position_count[62:31],
  // position[94:63], zero pad [95].
  input  logic [vbde_pkg::InDataWidth-1:0]     s_tdata,
  // Fields from bit 0: first_of_posting.
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // Fields from bit 0: byte_out[7:0].
  output logic [vbde_pkg::OutDataWidth-1:0]    m_tdata,
  output logic                                 m_tlast
);
  import vbde_pkg::*;

  vbde_cmd_t    cmd;
  vbde_status_t status;

  vbde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_first (s_tuser),
    .status   (status),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  vbde_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_first  (s_tuser),
    .in_doc    (s_tdata[30:0]),
    .in_count  (s_tdata[62:31]),
    .in_pos    (s_tdata[94:63]),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

  // An accepted beat always leaves the idle state for at least one byte.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("encoder took a beat but stayed ready");

  // The final byte of an item returns the controller to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> s_tready)
    else $error("encoder not ready after the final byte");

  // A continuation byte is never the last byte of an item.
  a_last_no_cont: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !m_tdata[7])
    else $error("last byte carries a continuation bit");

  // Bytes are only produced while the output register can take them.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("byte produced over a stalled output");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for posting_vbyte_delta_encoder: drives postings on the input
// stream, predicts every varint byte and its last flag, and checks the output stream.
// Depends on vbde_pkg and the posting_vbyte_delta_encoder top level.
module testbench;
  import vbde_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 32;
  localparam int unsigned ReportLimit   = 10;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } coded_byte_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [InDataWidth-1:0]  s_tdata = '0;
  logic                    s_tuser = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OutDataWidth-1:0] m_tdata;
  logic                    m_tlast;

  coded_byte_t pending_bytes[$];
  coded_byte_t rx_expected;
  logic [31:0] model_last_position = '0;
  int          error_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_mode_left = 0;
  logic [7:0]  rx_pattern = 8'hff;

  posting_vbyte_delta_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random value of a random bit width, so short and long varints both show up.
  function automatic logic [31:0] rand_bits(int unsigned max_width);
    int unsigned w;
    w = $urandom_range(1, max_width);
    return $urandom & (32'hffff_ffff >> (32 - w));
  endfunction

  task automatic queue_varint(input logic [31:0] value, input logic ends_item);
    while (value > 32'h7f) begin
      pending_bytes.push_back('{code: ContBit | {1'b0, value[6:0]}, last: 1'b0});
      value = value >> 7;
    end
    pending_bytes.push_back('{code: {1'b0, value[6:0]}, last: ends_item});
  endtask

  // Header on the first position of a posting, then the position delta.
  task automatic encode_posting_item(input logic first, input logic [30:0] doc,
                                     input logic [31:0] count, input logic [31:0] pos);
    logic [31:0] base;
    base = model_last_position;
    if (first) begin
      queue_varint({doc, count == 32'd1}, 1'b0);
      if (count > 32'd1) queue_varint(count, 1'b0);
      base = '0;
    end
    queue_varint(pos - base, 1'b1);
    model_last_position = pos;
  endtask

  task automatic send_item(input logic first, input logic [30:0] doc,
                           input logic [31:0] count, input logic [31:0] pos);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        s_tdata  <= {$urandom, $urandom, $urandom};
        s_tuser  <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= first;
    s_tdata  <= {1'b0, pos, count, doc};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    encode_posting_item(first, doc, count, pos);
    items_sent++;
    burst_left--;
  endtask

  task automatic test_directed_cases();
    logic [31:0] steps[8] = '{32'd127, 32'd128, 32'd16383, 32'd16384,
                              32'd2097151, 32'd2097152, 32'd268435455, 32'd268435456};
    logic [31:0] pos;
    // A position before any posting is coded against the reset value.
    send_item(1'b0, 31'd0, 32'd0, 32'd5);
    send_item(1'b1, 31'd1, 32'd1, 32'd0);
    // Largest header plus largest delta: fifteen bytes.
    send_item(1'b1, 31'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    // Descending positions wrap into a five-byte delta.
    send_item(1'b0, 31'd0, 32'd0, 32'h10);
    send_item(1'b0, 31'd0, 32'd0, 32'h0);
    // Document zero with a zero count: no single flag and no count varint.
    send_item(1'b1, 31'd0, 32'd0, 32'd127);
    send_item(1'b1, 31'd63, 32'd2, 32'd0);
    pos = '0;
    // More items than the count says; deltas straddle every group boundary.
    foreach (steps[i]) begin
      pos = pos + steps[i];
      send_item(1'b0, 31'd0, 32'd0, pos);
    end
    send_item(1'b1, 31'd64, 32'd127, 32'd128);
    send_item(1'b1, 31'h4000_0000, 32'd128, 32'd0);
    send_item(1'b1, 31'd2, 32'h8000_0000, 32'h8000_0000);
    send_item(1'b0, 31'd0, 32'd0, 32'hffff_ffff);
  endtask

  task automatic test_random_postings(input int target_items);
    logic [30:0] doc;
    logic [31:0] count;
    logic [31:0] pos;
    int          span;
    while (items_sent < target_items) begin
      doc   = 31'(rand_bits(31));
      count = ($urandom_range(0, 9) == 0) ? rand_bits(32) : $urandom_range(1, 6);
      span  = (count > 32'd8) ? $urandom_range(1, 8) : count;
      // Now and then the posting holds fewer or more items than its count.
      if ($urandom_range(0, 7) == 0) span = $urandom_range(1, 8);
      pos = ($urandom_range(0, 3) == 0) ? rand_bits(32) : rand_bits(12);
      send_item(1'b1, doc, count, pos);
      for (int k = 1; k < span; k++) begin
        pos = pos + (($urandom_range(0, 4) == 0) ? rand_bits(32) : rand_bits(10));
        send_item(1'b0, 31'd0, 32'd0, pos);
      end
    end
  endtask

  task automatic test_random_noise(input int target_items);
    while (items_sent < target_items)
      send_item($urandom_range(0, 2) == 0, 31'(rand_bits(31)), rand_bits(32), rand_bits(32));
  endtask

  // Output side: stall pattern that switches between modes, and the byte check.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(RX_OPEN, RX_PATTERN));
        rx_mode_left <= $urandom_range(32, 200);
        rx_pattern   <= 8'($urandom) | 8'h01;
      end else begin
        rx_mode_left <= rx_mode_left - 1;
        rx_pattern   <= {rx_pattern[0], rx_pattern[7:1]};
      end
      case (rx_mode)
        RX_OPEN:    m_tready <= 1'b1;
        RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE:  m_tready <= ($urandom_range(0, 3) == 0);
        default:    m_tready <= rx_pattern[0];
      endcase

      if (m_tvalid && m_tready) begin
        if (pending_bytes.size() == 0) begin
          if (error_count < ReportLimit)
            $display("unexpected beat: byte %02h last %0b", m_tdata, m_tlast);
          error_count++;
        end else begin
          rx_expected = pending_bytes.pop_front();
          if (m_tdata !== rx_expected.code || m_tlast !== rx_expected.last) begin
            if (error_count < ReportLimit)
              $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       rx_expected.code, rx_expected.last, m_tdata, m_tlast);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("** posting_vbyte_delta_encoder: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_postings(320);
    test_random_noise(420);
    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && pending_bytes.size() == 0)
      $display("** posting_vbyte_delta_encoder: PASSED **");
    else
      $display("** posting_vbyte_delta_encoder: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/vbde_pkg.sv
hdl/vbde_ctrl.sv
hdl/vbde_dp.sv
hdl/posting_vbyte_delta_encoder.sv
tb/sv/testbench.sv
